### design/assert_macros.svh
// Assertion helpers shared by the slot table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high.
`define DST_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define DST_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  `DST_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

### design/dst_pkg.sv
package dst_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [8:0] SLOT_LIMIT = 9'(TABLE_SLOTS);

  localparam int HANDLE_W = 32;
  localparam int SECTOR_W = 16;

  // request kinds
  localparam logic [2:0] KIND_ALLOC   = 3'd0;
  localparam logic [2:0] KIND_PLACE   = 3'd1;
  localparam logic [2:0] KIND_LOOKUP  = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;

  // result status codes
  localparam logic [2:0] STATUS_OK    = 3'd0;
  localparam logic [2:0] STATUS_NULL  = 3'd1;
  localparam logic [2:0] STATUS_RANGE = 3'd2;
  localparam logic [2:0] STATUS_BUSY  = 3'd3;
  localparam logic [2:0] STATUS_FREE  = 3'd4;
  localparam logic [2:0] STATUS_FULL  = 3'd5;

  typedef struct packed {
    logic accept;    // request taken this cycle
    logic load_out;  // move the finished result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } free_slot_t;

  // Priority encoder: lowest slot whose used mark is clear.
  function automatic free_slot_t lowest_free(input logic [TABLE_SLOTS-1:0] marks);
    free_slot_t res;
    res.found = 1'b0;
    res.slot  = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!marks[i]) begin
        res.found = 1'b1;
        res.slot  = SLOT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

### design/descriptor_slot_table_unit.sv
// Descriptor slot table: allocate, place, lookup, release and clear on a
// table of dst_pkg::TABLE_SLOTS slots.
// Decision registers and the entry RAM read load at the accept edge; the
// output register takes the result once it is free. The registered RAM
// read means a new request waits until that result enters the output register.
// Reset (rst, synchronous): all used marks clear, no result pending.
`include "assert_macros.svh"

module descriptor_slot_table_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   kind,
  input  logic [7:0]                   slot_index,
  input  logic [dst_pkg::HANDLE_W-1:0] object_handle,
  input  logic [dst_pkg::SECTOR_W-1:0] header_sector,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   status,
  output logic [7:0]                   granted_slot,
  output logic                         slot_used,
  output logic [dst_pkg::HANDLE_W-1:0] stored_handle,
  output logic [dst_pkg::SECTOR_W-1:0] stored_sector
);

  // Controller to datapath commands. The controller only sequences; every
  // table decision (lowest free slot, range and busy checks) is made in the
  // datapath in the accept cycle, so state updates land at the accept edge
  // and a following request always sees them.
  dst_pkg::dp_cmd_t cmd;

  // Controller: accepts a request in its idle state, waits in its read state for
  // the entry RAM read, then hands the result to the output register as soon as
  // that register is free. A new request can be taken while the previous
  // result still waits at the output.
  dst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_ready(out_ready),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  // Datapath: used marks in flip-flops, handle and sector stores in RAM,
  // decision registers and the output register.
  dst_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .kind         (kind),
    .slot_index   (slot_index),
    .object_handle(object_handle),
    .header_sector(header_sector),
    .status       (status),
    .granted_slot (granted_slot),
    .slot_used    (slot_used),
    .stored_handle(stored_handle),
    .stored_sector(stored_sector)
  );

  // A request is never taken while reset is applied.
  `DST_ASSERT_NEVER(a_no_accept_in_reset, clk, 1'b0, rst && in_valid && in_ready, "accept in reset")

endmodule

### design/dst_ram.sv
module dst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                   wr_data,
  input  logic                               rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                   rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/dst_ctrl.sv
`include "assert_macros.svh"

module dst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  output logic             in_ready,
  output logic             out_valid,
  output dst_pkg::dp_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  assign out_free     = !out_valid || out_ready;
  assign in_ready     = (state == S_IDLE) && !rst;
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.load_out = (state == S_READ) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept) state_next = S_READ;
      end
      S_READ: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DST_ASSERT(a_accept_to_read, clk, rst, cmd.accept |=> (state == S_READ) && !in_ready, "accepted request did not enter read state")
  `DST_ASSERT(a_load_sets_valid, clk, rst, cmd.load_out |=> out_valid, "loaded result not presented")
  `DST_ASSERT(a_hold_while_stalled, clk, rst, (state == S_READ) && out_valid && !out_ready |=> (state == S_READ) && !in_ready, "pending result dropped while output stalled")

endmodule

### design/dst_datapath.sv
`include "assert_macros.svh"

module dst_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  dst_pkg::dp_cmd_t               cmd,
  input  logic [2:0]                     kind,
  input  logic [7:0]                     slot_index,
  input  logic [dst_pkg::HANDLE_W-1:0]   object_handle,
  input  logic [dst_pkg::SECTOR_W-1:0]   header_sector,
  output logic [2:0]                     status,
  output logic [7:0]                     granted_slot,
  output logic                           slot_used,
  output logic [dst_pkg::HANDLE_W-1:0]   stored_handle,
  output logic [dst_pkg::SECTOR_W-1:0]   stored_sector
);

  logic [dst_pkg::TABLE_SLOTS-1:0] used_marks;
  logic [dst_pkg::TABLE_SLOTS-1:0] used_marks_next;

  logic                        in_range;
  logic [dst_pkg::SLOT_W-1:0]  idx;
  logic                        mark;
  logic                        null_handle;
  dst_pkg::free_slot_t         free_slot;

  logic [2:0]                  dec_status;
  logic [7:0]                  dec_granted;
  logic                        dec_used;
  logic                        dec_take_handle;
  logic                        dec_take_sector;
  logic                        wr_en;
  logic [dst_pkg::SLOT_W-1:0]  wr_addr;

  // decision held between accept and output load
  logic [2:0]                  res_status;
  logic [7:0]                  res_granted;
  logic                        res_used;
  logic                        res_take_handle;
  logic                        res_take_sector;

  logic [dst_pkg::HANDLE_W-1:0] rd_handle;
  logic [dst_pkg::SECTOR_W-1:0] rd_sector;

  assign in_range    = {1'b0, slot_index} < dst_pkg::SLOT_LIMIT;
  assign idx         = slot_index[dst_pkg::SLOT_W-1:0];
  assign mark        = in_range && used_marks[idx];
  assign null_handle = (object_handle == '0);
  assign free_slot   = dst_pkg::lowest_free(used_marks);

  always_comb begin
    dec_status      = dst_pkg::STATUS_OK;
    dec_granted     = slot_index;
    dec_used        = mark;
    dec_take_handle = 1'b0;
    dec_take_sector = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = idx;
    used_marks_next = used_marks;
    unique case (kind)
      dst_pkg::KIND_ALLOC: begin
        dec_used    = 1'b0;
        dec_granted = '0;
        if (null_handle) begin
          dec_status = dst_pkg::STATUS_NULL;
        end else if (!free_slot.found) begin
          dec_status = dst_pkg::STATUS_FULL;
        end else begin
          dec_granted                     = 8'(free_slot.slot);
          wr_en                           = 1'b1;
          wr_addr                         = free_slot.slot;
          used_marks_next[free_slot.slot] = 1'b1;
        end
      end
      dst_pkg::KIND_PLACE: begin
        if (null_handle) begin
          dec_status = dst_pkg::STATUS_NULL;
        end else if (!in_range) begin
          dec_status = dst_pkg::STATUS_RANGE;
        end else if (mark) begin
          dec_status = dst_pkg::STATUS_BUSY;
        end else begin
          wr_en                = 1'b1;
          used_marks_next[idx] = 1'b1;
        end
      end
      dst_pkg::KIND_LOOKUP: begin
        if (!in_range) begin
          dec_status = dst_pkg::STATUS_RANGE;
        end else if (!mark) begin
          dec_status = dst_pkg::STATUS_FREE;
        end else begin
          dec_take_handle = 1'b1;
          dec_take_sector = 1'b1;
        end
      end
      dst_pkg::KIND_RELEASE: begin
        if (!in_range) begin
          dec_status = dst_pkg::STATUS_RANGE;
        end else if (!mark) begin
          dec_status = dst_pkg::STATUS_FREE;
        end else begin
          dec_take_sector      = 1'b1;
          used_marks_next[idx] = 1'b0;
        end
      end
      dst_pkg::KIND_CLEAR: begin
        used_marks_next = '0;
      end
      default: begin
        // reserved kinds leave the table alone
      end
    endcase
  end

  dst_ram #(
    .WIDTH(dst_pkg::HANDLE_W),
    .DEPTH(dst_pkg::TABLE_SLOTS)
  ) u_handle_ram (
    .clk    (clk),
    .wr_en  (cmd.accept && wr_en),
    .wr_addr(wr_addr),
    .wr_data(object_handle),
    .rd_en  (cmd.accept),
    .rd_addr(idx),
    .rd_data(rd_handle)
  );

  dst_ram #(
    .WIDTH(dst_pkg::SECTOR_W),
    .DEPTH(dst_pkg::TABLE_SLOTS)
  ) u_sector_ram (
    .clk    (clk),
    .wr_en  (cmd.accept && wr_en),
    .wr_addr(wr_addr),
    .wr_data(header_sector),
    .rd_en  (cmd.accept),
    .rd_addr(idx),
    .rd_data(rd_sector)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used_marks <= '0;
    end else if (cmd.accept) begin
      used_marks <= used_marks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status      <= dec_status;
      res_granted     <= dec_granted;
      res_used        <= dec_used;
      res_take_handle <= dec_take_handle;
      res_take_sector <= dec_take_sector;
    end
    if (cmd.load_out) begin
      status        <= res_status;
      granted_slot  <= res_granted;
      slot_used     <= res_used;
      stored_handle <= res_take_handle ? rd_handle : '0;
      stored_sector <= res_take_sector ? rd_sector : '0;
    end
  end

  `DST_ASSERT_NEVER(a_write_free_only, clk, rst, cmd.accept && wr_en && used_marks[wr_addr], "entry write into a used slot")
  `DST_ASSERT(a_write_marks_used, clk, rst, cmd.accept && wr_en |=> used_marks[$past(wr_addr)], "written slot not marked used")
  `DST_ASSERT(a_clear_all, clk, rst, cmd.accept && (kind == dst_pkg::KIND_CLEAR) |=> (used_marks == '0), "clear left used marks set")

endmodule
